// ===== design/osi_pkg.sv =====
// shared types and opcode constants for the object script interpreter
package osi_pkg;

    localparam logic [7:0] OP_PRINT = 8'h10;
    localparam logic [7:0] OP_LDA_I = 8'hE0;
    localparam logic [7:0] OP_LDB_I = 8'hE1;
    localparam logic [7:0] OP_GETA  = 8'hE2;
    localparam logic [7:0] OP_GETB  = 8'hE3;
    localparam logic [7:0] OP_SETA  = 8'hE4;
    localparam logic [7:0] OP_SETB  = 8'hE5;
    localparam logic [7:0] OP_LDA_B = 8'hE6;
    localparam logic [7:0] OP_LDB_B = 8'hE7;
    localparam logic [7:0] OP_MOVAB = 8'hE8;
    localparam logic [7:0] OP_MOVBA = 8'hE9;
    localparam logic [7:0] OP_SWAP  = 8'hEA;
    localparam logic [7:0] OP_ADD   = 8'hD0;
    localparam logic [7:0] OP_SUB   = 8'hD1;
    localparam logic [7:0] OP_MUL   = 8'hD2;
    localparam logic [7:0] OP_DIV   = 8'hD3;
    localparam logic [7:0] OP_MOD   = 8'hD4;
    localparam logic [7:0] OP_ADDI  = 8'hD5;
    localparam logic [7:0] OP_SUBI  = 8'hD6;
    localparam logic [7:0] OP_PADDW = 8'hD7;
    localparam logic [7:0] OP_PSUBW = 8'hD8;
    localparam logic [7:0] OP_ADDB  = 8'hD9;
    localparam logic [7:0] OP_SUBB  = 8'hDA;
    localparam logic [7:0] OP_PADDB = 8'hDB;
    localparam logic [7:0] OP_PSUBB = 8'hDC;
    localparam logic [7:0] OP_SLPA  = 8'hFD;
    localparam logic [7:0] OP_SLPB  = 8'hFE;
    localparam logic [7:0] OP_SLPI  = 8'hFF;
    localparam logic [7:0] OP_SLPS  = 8'hFC;
    localparam logic [7:0] OP_PTI   = 8'hB0;
    localparam logic [7:0] OP_PTAB  = 8'hB1;
    localparam logic [7:0] OP_PTR   = 8'hB4;
    localparam logic [7:0] OP_LNR   = 8'hB6;
    localparam logic [7:0] OP_LNI   = 8'hB7;
    localparam logic [7:0] OP_JMP   = 8'hF0;
    localparam logic [7:0] OP_JLE   = 8'hF6;

    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_POINT = 3'd1;
    localparam logic [2:0] EV_LINE  = 3'd2;
    localparam logic [2:0] EV_SLEEP = 3'd3;
    localparam logic [2:0] EV_CLEAR = 3'd4;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BG     = 2'd2;
    localparam logic [1:0] CFG_START  = 2'd3;

    // request to the divider
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
        logic [15:0] rem;
    } div_rsp_t;

    // operand byte count per opcode, jumps handled by caller
    function automatic logic [3:0] operand_len(input logic [7:0] op);
        logic [3:0] n;
        begin
            n = 4'd0;
            unique case (op)
                8'hE0, 8'hE1, 8'hD5, 8'hD6, 8'hDB, 8'hDC,
                8'hFF, 8'hC1, 8'hC4: n = 4'd2;
                8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7,
                8'hD9, 8'hDA, 8'hFC, 8'hC2: n = 4'd1;
                8'hD7, 8'hD8: n = 4'd3;
                8'hC3, 8'hB2: n = 4'd4;
                8'hB0: n = 4'd5;
                8'hB7: n = 4'd9;
                default: n = 4'd0;
            endcase
            operand_len = n;
        end
    endfunction

endpackage

// ===== design/object_script_interpreter.sv =====
// top level: byte-stream decoder and executor for one display object
// sequence: a byte is taken and decoded in S_IDLE, executed in S_EXEC, then held in S_OUT until out_ready;
//   a divide or remainder with a nonzero divisor first waits in S_DIV for the bit-serial divider
// the sequencer holds one item at a time and takes no new byte until the result is accepted
// reset: registers, properties and flags clear, configuration takes its defaults
module object_script_interpreter
    import osi_pkg::*;
#(
    parameter int ADDR_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  cmd_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] fetch_addr,
    output logic        instr_done,
    output logic        unknown_op,
    output logic [2:0]  event_kind,
    output logic [15:0] ev_x,
    output logic [15:0] ev_y,
    output logic [15:0] ev_x2,
    output logic [15:0] ev_y2,
    output logic [7:0]  ev_color,
    output logic [15:0] ev_delay_ms,
    output logic        props_changed
);

    localparam logic [3:0] JMP_LEN = (ADDR_BITS > 8) ? 4'd2 : 4'd1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] width_reg, height_reg, bg_reg;
    logic [ADDR_BITS-1:0] pc_reg;
    logic [15:0] a_reg, b_reg;
    logic [15:0] props_reg [7];
    logic [15:0] draw_reg [5];
    logic [7:0]  op_reg;
    logic [3:0]  cnt_reg;
    logic [7:0]  buf_reg [9];
    logic        chg_reg;
    logic        done_reg;

    // output holding registers
    logic        o_done_reg, o_unk_reg;
    logic [2:0]  o_kind_reg;
    logic [15:0] o_x_reg, o_y_reg, o_x2_reg, o_y2_reg, o_delay_reg;
    logic [7:0]  o_color_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    osi_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    function automatic logic [3:0] op_len(input logic [7:0] op);
        begin
            if (op >= OP_JMP && op <= OP_JLE)
                op_len = JMP_LEN;
            else
                op_len = operand_len(op);
        end
    endfunction

    logic [7:0]  p;
    logic [15:0] imm0, imm1, imm2, imm4, imm6;
    logic [15:0] prop_val;
    logic [15:0] mul_full_lo;
    logic [3:0]  need;

    assign p    = buf_reg[0];
    assign imm0 = {buf_reg[0], buf_reg[1]};
    assign imm1 = {buf_reg[1], buf_reg[2]};
    assign imm2 = {buf_reg[2], buf_reg[3]};
    assign imm4 = {buf_reg[4], buf_reg[5]};
    assign imm6 = {buf_reg[6], buf_reg[7]};
    assign mul_full_lo = 16'(a_reg * b_reg);
    assign need = op_len(op_reg);

    // property read
    always_comb
    begin
        prop_val = 16'd0;
        if (p < 8'd7)
            prop_val = props_reg[p[2:0]];
        else if (p == 8'hD0)
            prop_val = width_reg;
        else if (p == 8'hD1)
            prop_val = height_reg;
        else if (p == 8'hD2)
            prop_val = bg_reg;
        else if (p >= 8'hF0 && p <= 8'hF4)
            prop_val = draw_reg[3'(p - 8'hF0)];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_EXEC;
            S_EXEC:
                if (done_reg && (op_reg == OP_DIV || op_reg == OP_MOD) && b_reg != 16'd0)
                    state_next = S_DIV;
                else
                    state_next = S_OUT;
            S_DIV:  if (div_rsp.done) state_next = S_OUT;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign div_req.start    = (state_reg == S_EXEC) && (state_next == S_DIV);
    assign div_req.dividend = a_reg;
    assign div_req.divisor  = b_reg;

    // control state and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            width_reg  <= 16'd640;
            height_reg <= 16'd480;
            bg_reg     <= 16'd0;
            pc_reg     <= '0;
            a_reg      <= 16'd0;
            b_reg      <= 16'd0;
            for (int i = 0; i < 7; i++) props_reg[i] <= 16'd0;
            for (int i = 0; i < 5; i++) draw_reg[i] <= 16'd0;
            op_reg     <= 8'd0;
            cnt_reg    <= 4'd0;
            chg_reg    <= 1'b0;
            done_reg   <= 1'b0;
            o_done_reg <= 1'b0;
            o_unk_reg  <= 1'b0;
            o_kind_reg <= EV_NONE;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WIDTH:  width_reg <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data;
                    CFG_BG:     bg_reg <= cfg_data;
                    CFG_START:
                    begin
                        pc_reg  <= cfg_data[ADDR_BITS-1:0];
                        cnt_reg <= 4'd0;
                    end
                    default: ;
                endcase
            end
            // byte acceptance: pc step and operand collection
            if (state_reg == S_IDLE && in_valid)
            begin
                pc_reg   <= pc_reg + 1'b1;
                done_reg <= 1'b0;
                if (cnt_reg == 4'd0)
                begin
                    op_reg <= cmd_byte;
                    if (op_len(cmd_byte) == 4'd0)
                        done_reg <= 1'b1;
                    else
                        cnt_reg <= 4'd1;
                end
                else if (cnt_reg > need || cnt_reg > 4'd9)
                    cnt_reg <= 4'd0;
                else if (cnt_reg == need)
                begin
                    done_reg <= 1'b1;
                    cnt_reg  <= 4'd0;
                end
                else
                    cnt_reg <= cnt_reg + 4'd1;
            end
            // execute the completed instruction
            if (state_reg == S_EXEC)
            begin
                o_done_reg <= done_reg;
                o_unk_reg  <= 1'b0;
                o_kind_reg <= EV_NONE;
                if (done_reg)
                begin
                    if (op_reg >= OP_JMP && op_reg <= OP_JLE)
                    begin
                        logic take;
                        take = 1'b0;
                        unique case (op_reg[2:0])
                            3'd0: take = 1'b1;
                            3'd1: take = a_reg == b_reg;
                            3'd2: take = a_reg != b_reg;
                            3'd3: take = a_reg > b_reg;
                            3'd4: take = a_reg >= b_reg;
                            3'd5: take = a_reg < b_reg;
                            default: take = a_reg <= b_reg;
                        endcase
                        if (take)
                            pc_reg <= (JMP_LEN == 4'd2) ? imm0[ADDR_BITS-1:0]
                                                        : ADDR_BITS'(buf_reg[0]);
                    end
                    else
                    begin
                        logic        wr;
                        logic [15:0] wv;
                        wr = 1'b0;
                        wv = 16'd0;
                        unique case (op_reg)
                            OP_PRINT: ;
                            OP_LDA_I: a_reg <= imm0;
                            OP_LDB_I: b_reg <= imm0;
                            OP_GETA:  a_reg <= prop_val;
                            OP_GETB:  b_reg <= prop_val;
                            OP_SETA:  begin wr = 1'b1; wv = a_reg; end
                            OP_SETB:  begin wr = 1'b1; wv = b_reg; end
                            OP_LDA_B: a_reg <= {8'd0, p};
                            OP_LDB_B: b_reg <= {8'd0, p};
                            OP_MOVAB: a_reg <= b_reg;
                            OP_MOVBA: b_reg <= a_reg;
                            OP_SWAP:  begin a_reg <= b_reg; b_reg <= a_reg; end
                            OP_ADD:   a_reg <= a_reg + b_reg;
                            OP_SUB:   a_reg <= a_reg - b_reg;
                            OP_MUL:   a_reg <= mul_full_lo;
                            OP_DIV:   if (b_reg == 16'd0) a_reg <= 16'hFFFF;
                            OP_MOD:   ;
                            OP_ADDI:  a_reg <= a_reg + imm0;
                            OP_SUBI:  a_reg <= a_reg - imm0;
                            OP_PADDW: begin wr = 1'b1; wv = prop_val + imm1; end
                            OP_PSUBW: begin wr = 1'b1; wv = prop_val - imm1; end
                            OP_ADDB:  a_reg <= a_reg + {8'd0, p};
                            OP_SUBB:  a_reg <= a_reg - {8'd0, p};
                            OP_PADDB: begin wr = 1'b1; wv = prop_val + {8'd0, buf_reg[1]}; end
                            OP_PSUBB: begin wr = 1'b1; wv = prop_val - {8'd0, buf_reg[1]}; end
                            OP_SLPA, OP_SLPB, OP_SLPI, OP_SLPS: o_kind_reg <= EV_SLEEP;
                            OP_PTI, OP_PTAB, OP_PTR: o_kind_reg <= EV_POINT;
                            OP_LNR, OP_LNI: o_kind_reg <= EV_LINE;
                            default: o_unk_reg <= 1'b1;
                        endcase
                        // property write
                        if (wr)
                        begin
                            if (p >= 8'hF0 && p <= 8'hF4)
                                draw_reg[3'(p - 8'hF0)] <= wv;
                            else
                            begin
                                o_kind_reg <= EV_CLEAR;
                                chg_reg    <= 1'b1;
                                if (p < 8'd7)
                                    props_reg[p[2:0]] <= wv;
                            end
                        end
                    end
                end
            end
            // divider result
            if (state_reg == S_DIV && div_rsp.done)
                a_reg <= (op_reg == OP_DIV) ? div_rsp.quot : div_rsp.rem;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && cnt_reg != 4'd0
            && !(cnt_reg > need || cnt_reg > 4'd9))
            buf_reg[cnt_reg - 4'd1] <= cmd_byte;
        if (state_reg == S_EXEC)
        begin
            o_x_reg     <= 16'd0;
            o_y_reg     <= 16'd0;
            o_x2_reg    <= 16'd0;
            o_y2_reg    <= 16'd0;
            o_color_reg <= 8'd0;
            o_delay_reg <= 16'd0;
            if (done_reg)
            begin
                unique case (op_reg)
                    OP_SLPA: o_delay_reg <= a_reg;
                    OP_SLPB: o_delay_reg <= b_reg;
                    OP_SLPI: o_delay_reg <= imm0;
                    OP_SLPS: o_delay_reg <= {8'd0, p};
                    OP_PTI:
                    begin
                        o_x_reg <= imm0; o_y_reg <= imm2; o_color_reg <= buf_reg[4];
                    end
                    OP_PTAB:
                    begin
                        o_x_reg <= a_reg; o_y_reg <= b_reg; o_color_reg <= draw_reg[0][7:0];
                    end
                    OP_PTR:
                    begin
                        o_x_reg <= draw_reg[1]; o_y_reg <= draw_reg[2];
                        o_color_reg <= draw_reg[0][7:0];
                    end
                    OP_LNR:
                    begin
                        o_x_reg <= draw_reg[1]; o_y_reg <= draw_reg[2];
                        o_x2_reg <= draw_reg[3]; o_y2_reg <= draw_reg[4];
                        o_color_reg <= draw_reg[0][7:0];
                    end
                    OP_LNI:
                    begin
                        o_x_reg <= imm0; o_y_reg <= imm2; o_x2_reg <= imm4;
                        o_y2_reg <= imm6; o_color_reg <= buf_reg[8];
                    end
                    default: ;
                endcase
            end
        end
    end

    assign fetch_addr    = 16'(pc_reg);
    assign instr_done    = o_done_reg;
    assign unknown_op    = o_unk_reg;
    assign event_kind    = o_kind_reg;
    assign ev_x          = o_x_reg;
    assign ev_y          = o_y_reg;
    assign ev_x2         = o_x2_reg;
    assign ev_y2         = o_y2_reg;
    assign ev_color      = o_color_reg;
    assign ev_delay_ms   = o_delay_reg;
    assign props_changed = chg_reg;

    // checks
    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIV) else $error("divider done outside wait");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> !in_ready) else $error("ready while executing");
    a_sticky_chg: assert property (@(posedge clk) disable iff (!rst_n)
        $past(chg_reg) |-> chg_reg) else $error("changed flag dropped");
    a_unk_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unknown_op |-> instr_done) else $error("unknown without completion");

endmodule

// ===== design/osi_divider.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module osi_divider
    import osi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [15:0] quot_reg, quot_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic [16:0] shifted;

    // one shift and subtract step
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quot_reg[15]};
        trial     = shifted - {1'b0, dvs_reg};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = 16'd0;
            dvs_next  = req.divisor;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[16])
            begin
                rem_next  = trial[15:0];
                quot_next = {quot_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[15:0];
                quot_next = {quot_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule
